FILE: src/rsa_modular_exponentiation_unit_macros.svh
// assertion macros for the rsa exponentiation unit checker
// expects signals named clk and rst in the scope of use
`ifndef RSA_MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define RSA_MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// same-cycle implication
`define RSA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsa checker: property failed");

// next-cycle implication
`define RSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsa checker: property failed");

`endif

FILE: src/rsa_pkg.sv
// shared types and constants for the rsa modular exponentiation unit
// no dependencies
package rsa_pkg;

  localparam int MSG_BITS      = 32;
  localparam int RES_BITS      = 32;
  localparam int MOD_BITS      = 32;
  localparam int PUB_BITS      = 8;
  localparam int PRIV_BITS     = 21;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [PUB_BITS-1:0]  E_LIMIT = PUB_BITS'(64);
  localparam logic [PRIV_BITS-1:0] D_LIMIT = PRIV_BITS'(1048576);

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS          = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_PUBLIC_EXPONENT  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_EXPONENT = CFG_IDX_BITS'(2);

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_INIT,
    ST_EXPO,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef enum logic {
    MUL_SQUARE,
    MUL_BASE
  } mul_kind_t;

endpackage

FILE: src/rsa_modular_exponentiation_unit.sv
// Computes message^e or message^d mod n by square-and-multiply on one shared
// modular add/compare-subtract unit. One item at a time: after a transfer on
// the s_ side the block checks the request, reduces the message mod n, sets up
// the accumulator and then walks the exponent from its top bit. Leading zero
// bits only shift the exponent; from the first set bit on, every bit costs a
// modular squaring and a modular multiply by the base where the bit is set.
// Each modular product does one double step per multiplier bit and one add
// step per set multiplier bit. A rejected request or a zero modulus skips the
// arithmetic. The result waits in an output register while the next item is
// taken in.
// Depends on rsa_pkg.
module rsa_modular_exponentiation_unit #(
  parameter int WORD_BITS = 32,
  parameter int EXP_BITS  = 21
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rsa_pkg::MSG_BITS-1:0]       s_tdata,  // message
  input  logic                               s_tuser,  // op
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rsa_pkg::RES_BITS-1:0]       m_tdata,  // result
  output logic                               m_tuser   // error
);

  localparam int W         = WORD_BITS;
  localparam int BCNT_BITS = $clog2(WORD_BITS);
  localparam int ECNT_BITS = $clog2(EXP_BITS);

  rsa_pkg::state_t    state, state_next;
  rsa_pkg::mul_kind_t mulk, mulk_next;

  logic [rsa_pkg::MOD_BITS-1:0]  modulus;
  logic [rsa_pkg::PUB_BITS-1:0]  public_exponent;
  logic [rsa_pkg::PRIV_BITS-1:0] private_exponent;

  logic                 op_q, op_q_next;
  logic                 err_q, err_q_next;
  logic                 started, started_next;
  logic                 phase, phase_next;
  logic [W-1:0]         acc, acc_next;
  logic [W-1:0]         prod, prod_next;
  logic [W-1:0]         base, base_next;
  logic [W-1:0]         ma, ma_next;
  logic [W-1:0]         mb, mb_next;
  logic [EXP_BITS-1:0]  expo, expo_next;
  logic [ECNT_BITS-1:0] ecnt, ecnt_next;
  logic [BCNT_BITS-1:0] bcnt, bcnt_next;

  logic [63:0]  n_ext, msg_ext, e_ext, acc_ext;
  logic [W-1:0] n_w, msg_w;
  logic [W:0]   u_in, u_sub, n_x;
  logic [W-1:0] u_out;
  logic         req_err, mod_zero;
  logic         exp_bit, exp_last, mul_step_done, mul_last;
  logic         out_load;

  // word views
  assign n_ext   = 64'(modulus);
  assign n_w     = n_ext[W-1:0];
  assign n_x     = {1'b0, n_w};
  assign msg_ext = 64'(s_tdata);
  assign msg_w   = msg_ext[W-1:0];
  assign e_ext   = (op_q == rsa_pkg::OP_DECRYPT) ? 64'(private_exponent)
                                                 : 64'(public_exponent);
  assign acc_ext = 64'(acc);

  assign req_err  = (op_q == rsa_pkg::OP_DECRYPT) ?
                    (private_exponent > rsa_pkg::D_LIMIT) :
                    ((public_exponent > rsa_pkg::E_LIMIT) || (mb > n_w));
  assign mod_zero = (n_w == '0);

  assign exp_bit       = expo[EXP_BITS-1];
  assign exp_last      = (ecnt == '0);
  assign mul_step_done = phase || !mb[W-1];
  assign mul_last      = mul_step_done && (bcnt == '0);

  // shared unit: x < 2n in, x mod n out
  always_comb begin
    unique case (state)
      rsa_pkg::ST_REDUCE: u_in = {prod, mb[W-1]};
      rsa_pkg::ST_INIT:   u_in = (W+1)'(1);
      rsa_pkg::ST_MUL:    u_in = phase ? ({1'b0, prod} + {1'b0, ma}) : {prod, 1'b0};
      default:            u_in = '0;
    endcase
  end

  assign u_sub = u_in - n_x;
  assign u_out = (u_in >= n_x) ? u_sub[W-1:0] : u_in[W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rsa_pkg::ST_IDLE:   if (s_tvalid) state_next = rsa_pkg::ST_CHECK;
      rsa_pkg::ST_CHECK: begin
        if (req_err || mod_zero) state_next = rsa_pkg::ST_DONE;
        else                     state_next = rsa_pkg::ST_REDUCE;
      end
      rsa_pkg::ST_REDUCE: if (bcnt == '0) state_next = rsa_pkg::ST_INIT;
      rsa_pkg::ST_INIT:   state_next = rsa_pkg::ST_EXPO;
      rsa_pkg::ST_EXPO: begin
        if (!started && !exp_bit) begin
          if (exp_last) state_next = rsa_pkg::ST_DONE;
        end else begin
          state_next = rsa_pkg::ST_MUL;
        end
      end
      rsa_pkg::ST_MUL: begin
        if (mul_last && !(mulk == rsa_pkg::MUL_SQUARE && exp_bit)) begin
          state_next = exp_last ? rsa_pkg::ST_DONE : rsa_pkg::ST_EXPO;
        end
      end
      rsa_pkg::ST_DONE:   if (!m_tvalid || m_tready) state_next = rsa_pkg::ST_IDLE;
      default:            state_next = rsa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = (state == rsa_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    out_load  = (state == rsa_pkg::ST_DONE) && (!m_tvalid || m_tready);
  end

  // datapath next values
  always_comb begin
    op_q_next    = op_q;
    err_q_next   = err_q;
    started_next = started;
    phase_next   = phase;
    mulk_next    = mulk;
    acc_next     = acc;
    prod_next    = prod;
    base_next    = base;
    ma_next      = ma;
    mb_next      = mb;
    expo_next    = expo;
    ecnt_next    = ecnt;
    bcnt_next    = bcnt;
    unique case (state)
      rsa_pkg::ST_IDLE: begin
        op_q_next = s_tuser;
        mb_next   = msg_w;
      end
      rsa_pkg::ST_CHECK: begin
        err_q_next = req_err;
        acc_next   = '0;
        prod_next  = '0;
        bcnt_next  = BCNT_BITS'(W - 1);
        expo_next  = e_ext[EXP_BITS-1:0];
        ecnt_next  = ECNT_BITS'(EXP_BITS - 1);
      end
      rsa_pkg::ST_REDUCE: begin
        prod_next = u_out;
        mb_next   = mb << 1;
        bcnt_next = bcnt - 1'b1;
        if (bcnt == '0) base_next = u_out;
      end
      rsa_pkg::ST_INIT: begin
        acc_next     = u_out;
        started_next = 1'b0;
      end
      rsa_pkg::ST_EXPO: begin
        if (!started && !exp_bit) begin
          expo_next = expo << 1;
          ecnt_next = ecnt - 1'b1;
        end else begin
          started_next = 1'b1;
          ma_next      = acc;
          mb_next      = acc;
          prod_next    = '0;
          bcnt_next    = BCNT_BITS'(W - 1);
          phase_next   = 1'b0;
          mulk_next    = rsa_pkg::MUL_SQUARE;
        end
      end
      rsa_pkg::ST_MUL: begin
        prod_next = u_out;
        if (!phase && mb[W-1]) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          mb_next    = mb << 1;
          bcnt_next  = bcnt - 1'b1;
          if (bcnt == '0) begin
            acc_next = u_out;
            if (mulk == rsa_pkg::MUL_SQUARE && exp_bit) begin
              ma_next   = u_out;
              mb_next   = base;
              prod_next = '0;
              bcnt_next = BCNT_BITS'(W - 1);
              mulk_next = rsa_pkg::MUL_BASE;
            end else begin
              expo_next = expo << 1;
              ecnt_next = ecnt - 1'b1;
            end
          end
        end
      end
      rsa_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q    <= op_q_next;
    err_q   <= err_q_next;
    started <= started_next;
    phase   <= phase_next;
    mulk    <= mulk_next;
    acc     <= acc_next;
    prod    <= prod_next;
    base    <= base_next;
    ma      <= ma_next;
    mb      <= mb_next;
    expo    <= expo_next;
    ecnt    <= ecnt_next;
    bcnt    <= bcnt_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= rsa_pkg::MOD_BITS'(1);
      public_exponent  <= '0;
      private_exponent <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rsa_pkg::CFG_MODULUS:
          modulus <= cfg_data[rsa_pkg::MOD_BITS-1:0];
        rsa_pkg::CFG_PUBLIC_EXPONENT:
          public_exponent <= cfg_data[rsa_pkg::PUB_BITS-1:0];
        rsa_pkg::CFG_PRIVATE_EXPONENT:
          private_exponent <= cfg_data[rsa_pkg::PRIV_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= acc_ext[rsa_pkg::RES_BITS-1:0];
      m_tuser <= err_q;
    end
  end

endmodule

FILE: src/rsa_checker.sv
// port-level checks for the rsa modular exponentiation unit, bound to the top
// depends on rsa_pkg and rsa_modular_exponentiation_unit_macros.svh
`include "rsa_modular_exponentiation_unit_macros.svh"

module rsa_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rsa_pkg::RES_BITS-1:0] m_tdata,
  input logic                         m_tuser
);

  // a stalled result holds
  `RSA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // a rejected request carries a zero result
  `RSA_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == '0)

  // one item at a time
  `RSA_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)

endmodule

bind rsa_modular_exponentiation_unit rsa_checker u_rsa_checker (.*);

FILE: tb/rsa_modexp_checker.sv
// checker for the rsa modular exponentiation unit: follows the key register writes,
// predicts each result by square-and-multiply and compares it with the output stream
// depends on rsa_pkg
module rsa_modexp_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [rsa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [rsa_pkg::MSG_BITS-1:0]       s_tdata,
  input  logic                               s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [rsa_pkg::RES_BITS-1:0]       m_tdata,
  input  logic                               m_tuser,
  output int                                 outstanding,
  output int                                 mismatches
);
  import rsa_pkg::*;

  typedef struct packed {
    logic [RES_BITS-1:0] value;
    logic                flag;
  } power_t;

  logic [MOD_BITS-1:0]  key_modulus;
  logic [PUB_BITS-1:0]  key_public;
  logic [PRIV_BITS-1:0] key_private;
  power_t               powers_due[$];
  power_t               due;
  int                   fails;

  function automatic logic [RES_BITS-1:0] mod_power(input logic [MSG_BITS-1:0] base,
                                                     input logic [PRIV_BITS-1:0] expo,
                                                     input logic [MOD_BITS-1:0] n);
    logic [63:0] acc;
    logic [63:0] b;
    int          i;
    if (n == '0) return '0;
    b   = 64'(base) % 64'(n);
    acc = 64'd1 % 64'(n);
    for (i = PRIV_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % 64'(n);
      if (expo[i]) acc = (acc * b) % 64'(n);
    end
    return acc[RES_BITS-1:0];
  endfunction

  function automatic power_t predict_power(input logic op, input logic [MSG_BITS-1:0] msg);
    power_t p;
    if (op == OP_ENCRYPT) p.flag = (key_public > E_LIMIT) || (msg > key_modulus);
    else p.flag = key_private > D_LIMIT;
    if (p.flag) p.value = '0;
    else if (op == OP_ENCRYPT) p.value = mod_power(msg, PRIV_BITS'(key_public), key_modulus);
    else p.value = mod_power(msg, key_private, key_modulus);
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_modulus = MOD_BITS'(1);
      key_public  = '0;
      key_private = '0;
      powers_due.delete();
      outstanding <= 0;
      mismatches  <= 0;
    end else begin
      fails = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODULUS:          key_modulus = cfg_data[MOD_BITS-1:0];
          CFG_PUBLIC_EXPONENT:  key_public  = cfg_data[PUB_BITS-1:0];
          CFG_PRIVATE_EXPONENT: key_private = cfg_data[PRIV_BITS-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (powers_due.size() == 0) begin
          $error("result transfer with no result due: result %0h, error %0b", m_tdata, m_tuser);
          fails++;
        end else begin
          due = powers_due.pop_front();
          if (m_tdata !== due.value) begin
            $error("result mismatch: expected %0h, actual %0h", due.value, m_tdata);
            fails++;
          end
          if (m_tuser !== due.flag) begin
            $error("error mismatch: expected %0b, actual %0b", due.flag, m_tuser);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) powers_due.push_back(predict_power(s_tuser, s_tdata));
      outstanding <= powers_due.size();
      mismatches  <= mismatches + fails;
    end
  end

endmodule

FILE: tb/tb.sv
// top of the rsa exponentiation unit testbench: clock, reset, key writes and message
// stimulus with varying back-pressure; verdict from rsa_modexp_checker
// depends on rsa_pkg, rsa_modular_exponentiation_unit and rsa_modexp_checker
module tb;
  import rsa_pkg::*;

  localparam int ITEM_TARGET   = 400;
  localparam int STALL_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 6000;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = CFG_IDX_BITS'(3);

  typedef enum logic [1:0] {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL
  } pace_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [MSG_BITS-1:0]       s_tdata   = '0;
  logic                      s_tuser   = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [RES_BITS-1:0]       m_tdata;
  logic                      m_tuser;

  int    outstanding;
  int    mismatches;
  int    quiet_cycles = 0;
  int    items_sent   = 0;
  pace_t pace         = PACE_SLOW_SINK;

  rsa_modular_exponentiation_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rsa_modexp_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .outstanding(outstanding), .mismatches(mismatches)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else case (pace)
      PACE_SLOW_SINK:   m_tready <= $urandom_range(99) >= 46;
      PACE_SLOW_SOURCE: m_tready <= $urandom_range(99) >= 23;
      default:          m_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb failed");
    $finish;
  end

  function automatic bit source_rests();
    case (pace)
      PACE_SLOW_SINK:   return $urandom_range(99) < 23;
      PACE_SLOW_SOURCE: return $urandom_range(99) < 46;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic [MOD_BITS-1:0] random_modulus();
    case ($urandom_range(9))
      0:       return MOD_BITS'($urandom_range(1));
      1, 2:    return MOD_BITS'($urandom_range(65535, 2));
      3:       return 32'hFFFF_FFFF - MOD_BITS'($urandom_range(255));
      default: return MOD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PUB_BITS-1:0] random_public();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return PUB_BITS'(1);
          2:       return E_LIMIT;
          3:       return E_LIMIT + PUB_BITS'(1);
          default: return '1;
        endcase
      end
      1:       return PUB_BITS'($urandom_range(255, 65));
      default: return PUB_BITS'($urandom_range(64));
    endcase
  endfunction

  function automatic logic [PRIV_BITS-1:0] random_private();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0:       return '0;
          1:       return PRIV_BITS'(1);
          2:       return D_LIMIT - PRIV_BITS'(1);
          3:       return D_LIMIT;
          4:       return D_LIMIT + PRIV_BITS'(1);
          default: return '1;
        endcase
      end
      1:       return PRIV_BITS'($urandom_range(2097151, 1048577));
      default: return PRIV_BITS'($urandom_range(1048576));
    endcase
  endfunction

  // messages cluster around the modulus to hit the range check from both sides
  function automatic logic [MSG_BITS-1:0] pick_message(input logic [MOD_BITS-1:0] key_n);
    case ($urandom_range(9))
      0, 1, 2, 3: return MSG_BITS'({32'h0, 32'($urandom)} % ({32'h0, key_n} + 64'd1));
      4:          return key_n;
      5:          return key_n + MSG_BITS'(1);
      6:          return MSG_BITS'($urandom_range(15));
      default:    return MSG_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [MSG_BITS-1:0] msg);
    while (source_rests()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= msg;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (items_sent >= 2 * ITEM_TARGET / 3) pace = PACE_FULL;
    else if (items_sent >= ITEM_TARGET / 3) pace = PACE_SLOW_SOURCE;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers change only with the unit idle; upper data bits are don't-care noise
  task automatic load_key(input logic [MOD_BITS-1:0] key_n, input logic [PUB_BITS-1:0] key_e,
                          input logic [PRIV_BITS-1:0] key_d);
    drain();
    write_reg(CFG_MODULUS, key_n);
    write_reg(CFG_PUBLIC_EXPONENT, ($urandom & 32'hFFFF_FF00) | 32'(key_e));
    write_reg(CFG_PRIVATE_EXPONENT, ($urandom & 32'hFFE0_0000) | 32'(key_d));
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [MOD_BITS-1:0] key_n;
    int                  batch;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset key: modulus 1, both exponents zero
    send_item(OP_ENCRYPT, 32'h0);
    send_item(OP_ENCRYPT, 32'h1);
    send_item(OP_ENCRYPT, 32'h2);
    send_item(OP_DECRYPT, 32'hFFFF_FFFF);

    // widest modulus, exponents at their limits
    load_key(32'hFFFF_FFFF, E_LIMIT, D_LIMIT);
    send_item(OP_ENCRYPT, 32'hFFFF_FFFF);
    send_item(OP_ENCRYPT, 32'h1234_5678);
    send_item(OP_DECRYPT, 32'hFFFF_FFFE);
    send_item(OP_DECRYPT, 32'h0);
    send_item(OP_ENCRYPT, 32'h0);

    // exponents just past their limits
    load_key(32'h0, E_LIMIT + PUB_BITS'(1), D_LIMIT + PRIV_BITS'(1));
    send_item(OP_ENCRYPT, 32'h0);
    send_item(OP_DECRYPT, 32'h5);

    // zero modulus with exponents within their limits
    load_key(32'h0, PUB_BITS'(3), '0);
    send_item(OP_ENCRYPT, 32'h0);
    send_item(OP_DECRYPT, 32'hFFFF_FFFF);
    send_item(OP_ENCRYPT, 32'h1);

    // small textbook key
    load_key(32'd3233, PUB_BITS'(17), PRIV_BITS'(2753));
    send_item(OP_ENCRYPT, 32'd65);
    send_item(OP_DECRYPT, 32'd2790);
    send_item(OP_ENCRYPT, 32'd3233);
    send_item(OP_ENCRYPT, 32'd3234);
    send_item(OP_DECRYPT, 32'd100000);

    // all-ones exponents
    load_key(32'hFFFF_FFFB, '1, '1);
    send_item(OP_ENCRYPT, 32'h1);
    send_item(OP_DECRYPT, 32'h1);

    while (items_sent < ITEM_TARGET) begin
      key_n = random_modulus();
      load_key(key_n, random_public(), random_private());
      batch = $urandom_range(35, 15);
      repeat (batch) send_item(1'($urandom_range(1)), pick_message(key_n));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
